// ----- hdl/rmts_pkg.sv -----
`default_nettype none

package rmts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int ID_W   = 23;
  localparam int PER_W  = 16;
  localparam int UTIL_W = 20;
  localparam int PROD_W = PER_W + UTIL_W;

  localparam logic [UTIL_W-1:0] UTIL_MAX       = 20'hFFFFF;
  localparam logic [UTIL_W-1:0] PPM_SCALE      = 20'd1000000;
  localparam logic [UTIL_W-1:0] UTIL_BOUND_RST = 20'd693000;

  // word select bit of paddr
  localparam logic CFG_UTIL_BOUND = 1'b0;

  typedef enum logic [1:0] {
    FN_REGISTER   = 2'd0,
    FN_YIELD      = 2'd1,
    FN_DEREGISTER = 2'd2,
    FN_TICK       = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_REFUSED = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_SKIPPED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RS_SLEEP = 2'd0,
    RS_READY = 2'd1,
    RS_RUN   = 2'd2
  } run_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_ADMIT,
    S_LAUNCH,
    S_SWEEP
  } ctrl_state_e;

  typedef struct packed {
    func_e             func;
    logic [ID_W-1:0]   task_id;
    logic [PER_W-1:0]  period_ticks;
    logic [PER_W-1:0]  compute_ticks;
  } rmts_in_t;

  typedef struct packed {
    status_e           status;
    logic              running_valid;
    logic [ID_W-1:0]   running_id;
    logic              preempt_valid;
    logic [ID_W-1:0]   preempted_id;
  } rmts_out_t;

  // operation broadcast to every cell during a sweep
  typedef struct packed {
    func_e             func;
    logic [ID_W-1:0]   task_id;
    logic [PER_W-1:0]  period;
    logic [UTIL_W-1:0] util;
    logic              admit;
  } rmts_cmd_t;

  // sweep token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic              skip;
    logic [UTIL_W-1:0] hit_util;
    logic              best_vld;
    logic [PER_W-1:0]  best_per;
    logic [ID_W-1:0]   best_id;
    logic              run_ok;
    logic [PER_W-1:0]  run_per;
    logic [ID_W-1:0]   run_id;
  } rmts_tok_t;

endpackage

`default_nettype wire

// ----- hdl/rmts_div.sv -----
`default_nettype none

module rmts_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rmts_pkg::PROD_W-1:0] num_i,
  input  logic [rmts_pkg::PER_W-1:0]  den_i,
  output logic                       done_o,
  output logic [rmts_pkg::PROD_W-1:0] quo_o
);
  import rmts_pkg::*;

  localparam int CW = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] nq_q, nq_d;
  logic [PER_W:0]    rem_q, rem_d, rem_sh;
  logic [PER_W-1:0]  den_q, den_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[PER_W-1:0], nq_q[PROD_W-1]};
    if (start_i) begin
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(PROD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        nq_d  = {nq_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        nq_d  = {nq_q[PROD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

`default_nettype wire

// ----- hdl/rmts_cell.sv -----
`default_nettype none

module rmts_cell #(
  parameter int TASK_SLOTS = rmts_pkg::TASK_SLOTS_DEF,
  parameter int TIME_WIDTH = rmts_pkg::TIME_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmts_pkg::rmts_cmd_t           cmd_i,
  input  logic [TIME_WIDTH-1:0]         now_i,
  input  logic [$clog2(TASK_SLOTS)-1:0] run_slot_i,
  input  logic                          run_pres_i,
  input  logic                          start_en_i,
  input  logic [$clog2(TASK_SLOTS)-1:0] start_idx_i,
  input  logic                          stop_en_i,
  input  logic [$clog2(TASK_SLOTS)-1:0] stop_idx_i,
  input  rmts_pkg::rmts_tok_t           tok_i,
  input  logic [$clog2(TASK_SLOTS)-1:0] hidx_i,
  input  logic [$clog2(TASK_SLOTS)-1:0] bidx_i,
  output rmts_pkg::rmts_tok_t           tok_o,
  output logic [$clog2(TASK_SLOTS)-1:0] hidx_o,
  output logic [$clog2(TASK_SLOTS)-1:0] bidx_o
);
  import rmts_pkg::*;

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int TW = TIME_WIDTH;

  logic              used_q, used_d, armed_q, armed_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [PER_W-1:0]  per_q, per_d;
  logic [UTIL_W-1:0] util_q, util_d;
  run_state_e        st_q, st_d;
  logic [TW-1:0]     rel_q, rel_d, rel_sum;
  rmts_tok_t         tok_q, tok_d;
  logic [IW-1:0]     hidx_q, hidx_d, bidx_q, bidx_d, me;
  logic              hit;

  assign me = IW'(IDX);

  always_comb begin
    used_d  = used_q;
    armed_d = armed_q;
    id_d    = id_q;
    per_d   = per_q;
    util_d  = util_q;
    st_d    = st_q;
    rel_d   = rel_q;
    tok_d   = tok_i;
    hidx_d  = hidx_i;
    bidx_d  = bidx_i;
    hit     = 1'b0;
    rel_sum = ((rel_q == '0) ? now_i : rel_q) + TW'(per_q);
    if (tok_i.vld) begin
      unique case (cmd_i.func)
        FN_REGISTER: begin
          if (cmd_i.admit && !tok_i.hit && !used_q) begin
            hit     = 1'b1;
            used_d  = 1'b1;
            id_d    = cmd_i.task_id;
            per_d   = cmd_i.period;
            util_d  = cmd_i.util;
            st_d    = RS_SLEEP;
            rel_d   = '0;
            armed_d = 1'b0;
          end
        end
        FN_YIELD: begin
          if (!tok_i.hit && used_q && id_q == cmd_i.task_id) begin
            hit   = 1'b1;
            rel_d = rel_sum;
            if (rel_sum < now_i) begin
              tok_d.skip = 1'b1;
            end else begin
              armed_d = 1'b1;
              st_d    = RS_SLEEP;
            end
          end
        end
        FN_DEREGISTER: begin
          if (!tok_i.hit && used_q && id_q == cmd_i.task_id) begin
            hit            = 1'b1;
            used_d         = 1'b0;
            armed_d        = 1'b0;
            st_d           = RS_SLEEP;
            tok_d.hit_util = util_q;
          end
        end
        FN_TICK: begin
          if (used_q && armed_q && rel_q <= now_i) begin
            st_d    = RS_READY;
            armed_d = 1'b0;
          end
        end
        default: ;
      endcase
      if (hit) begin
        tok_d.hit = 1'b1;
        hidx_d    = me;
      end
      // dispatch search sees this slot after the action
      if (used_d && st_d == RS_READY && (!tok_i.best_vld || per_d < tok_i.best_per)) begin
        tok_d.best_vld = 1'b1;
        tok_d.best_per = per_d;
        tok_d.best_id  = id_d;
        bidx_d         = me;
      end
      if (run_pres_i && run_slot_i == me) begin
        tok_d.run_ok  = used_d && st_d == RS_RUN;
        tok_d.run_per = per_d;
        tok_d.run_id  = id_d;
      end
    end else begin
      if (stop_en_i && stop_idx_i == me) begin
        st_d = RS_READY;
      end
      if (start_en_i && start_idx_i == me) begin
        st_d = RS_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      armed_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      used_q  <= used_d;
      armed_q <= armed_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    per_q  <= per_d;
    util_q <= util_d;
    st_q   <= st_d;
    rel_q  <= rel_d;
    hidx_q <= hidx_d;
    bidx_q <= bidx_d;
  end

  assign tok_o  = tok_q;
  assign hidx_o = hidx_q;
  assign bidx_o = bidx_q;

endmodule

`default_nettype wire

// ----- hdl/rate_monotonic_task_scheduler_core.sv -----
`default_nettype none

// Rate-monotonic task scheduler with utilization admission.
// Command channel: drive cmd_i and raise start; the command is transferred at
// the clock edge where start is high and busy is low. Each command yields one
// result on res_o, shown for exactly one cycle while done_o is high; the
// receiver cannot stall it, so sample it in that cycle.
// Sequencing: for yield, deregister and tick, one sweep token walks the slot
// cell chain between transfer and done_o, one cell per cycle. A register command
// puts the ppm multiply, the bit-serial divider and the admission check in front
// of that; a zero period skips the divider. busy drops the cycle the result is
// registered, so a new command may be transferred while the previous result
// is on res_o.
// Config: util_bound_ppm on the APB port at byte address 0, reset 693000;
// write it only while the block is idle.
// Reset: all slots free, time zero, no running task, total utilization zero.
module rate_monotonic_task_scheduler_core #(
  parameter int TASK_SLOTS = rmts_pkg::TASK_SLOTS_DEF,
  parameter int TIME_WIDTH = rmts_pkg::TIME_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  rmts_pkg::rmts_in_t  cmd_i,
  output logic                done_o,
  output rmts_pkg::rmts_out_t res_o
);
  import rmts_pkg::*;

  localparam int IW    = $clog2(TASK_SLOTS);
  localparam int TW    = TIME_WIDTH;
  localparam int TOT_W = UTIL_W + $clog2(TASK_SLOTS);

  ctrl_state_e       state_q, state_d;
  logic [UTIL_W-1:0] bound_q;
  logic [TW-1:0]     now_q, now_d;
  logic [IW-1:0]     run_slot_q, run_slot_d;
  logic              run_pres_q, run_pres_d, rp;
  logic [TOT_W-1:0]  total_q, total_d;
  rmts_in_t          op_q, op_d;
  logic [UTIL_W-1:0] util_q, util_d;
  logic              admit_q, admit_d;
  logic [PROD_W-1:0] prod_q, prod_d, quo;
  rmts_out_t         res_q, res_d;
  logic              done_q, done_d;
  logic              div_start, div_done, launch, cfg_wr;
  logic              start_en, stop_en;
  logic [IW-1:0]     start_idx, stop_idx;
  rmts_cmd_t         bcast;

  // token chain: entry k feeds cell k, entry TASK_SLOTS is the chain output
  rmts_tok_t         tok  [TASK_SLOTS+1];
  logic [IW-1:0]     hidx [TASK_SLOTS+1];
  logic [IW-1:0]     bidx [TASK_SLOTS+1];
  rmts_tok_t         tok_end;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_UTIL_BOUND);
  assign prdata = (paddr[2] == CFG_UTIL_BOUND) ? {12'b0, bound_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= UTIL_BOUND_RST;
    end else if (cfg_wr) begin
      bound_q <= pwdata[UTIL_W-1:0];
    end
  end

  rmts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q),
    .den_i  (op_q.period_ticks),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign bcast.func    = op_q.func;
  assign bcast.task_id = op_q.task_id;
  assign bcast.period  = op_q.period_ticks;
  assign bcast.util    = util_q;
  assign bcast.admit   = admit_q;

  // inject an empty token at the chain head
  always_comb begin
    tok[0]     = '0;
    tok[0].vld = launch;
  end
  assign hidx[0] = '0;
  assign bidx[0] = '0;

  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    rmts_cell #(
      .TASK_SLOTS(TASK_SLOTS),
      .TIME_WIDTH(TIME_WIDTH),
      .IDX       (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (bcast),
      .now_i      (now_q),
      .run_slot_i (run_slot_q),
      .run_pres_i (run_pres_q),
      .start_en_i (start_en),
      .start_idx_i(start_idx),
      .stop_en_i  (stop_en),
      .stop_idx_i (stop_idx),
      .tok_i      (tok[g]),
      .hidx_i     (hidx[g]),
      .bidx_i     (bidx[g]),
      .tok_o      (tok[g+1]),
      .hidx_o     (hidx[g+1]),
      .bidx_o     (bidx[g+1])
    );
  end

  assign tok_end = tok[TASK_SLOTS];

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    run_slot_d = run_slot_q;
    run_pres_d = run_pres_q;
    total_d    = total_q;
    op_d       = op_q;
    util_d     = util_q;
    admit_d    = admit_q;
    prod_d     = prod_q;
    res_d      = res_q;
    done_d     = 1'b0;
    div_start  = 1'b0;
    launch     = 1'b0;
    start_en   = 1'b0;
    stop_en    = 1'b0;
    start_idx  = bidx[TASK_SLOTS];
    stop_idx   = run_slot_q;
    rp         = run_pres_q && tok_end.run_ok;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = cmd_i;
          if (cmd_i.func == FN_REGISTER) begin
            state_d = S_MUL;
          end else begin
            admit_d = 1'b0;
            util_d  = '0;
            if (cmd_i.func == FN_TICK) begin
              now_d = now_q + 1'b1;
            end
            state_d = S_LAUNCH;
          end
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(op_q.compute_ticks) * PROD_W'(PPM_SCALE);
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        if (op_q.period_ticks == '0) begin
          util_d  = UTIL_MAX;
          state_d = S_ADMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          // saturate the per-task utilization
          util_d  = (|quo[PROD_W-1:UTIL_W]) ? UTIL_MAX : quo[UTIL_W-1:0];
          state_d = S_ADMIT;
        end
      end
      S_ADMIT: begin
        admit_d = ({1'b0, total_q} + (TOT_W+1)'(util_q)) <= (TOT_W+1)'(bound_q);
        state_d = S_LAUNCH;
      end
      S_LAUNCH: begin
        launch  = 1'b1;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (tok_end.vld) begin
          res_d.status = ST_OK;
          unique case (op_q.func)
            FN_REGISTER: begin
              if (!admit_q) begin
                res_d.status = ST_REFUSED;
              end else if (!tok_end.hit) begin
                res_d.status = ST_FULL;
              end else begin
                total_d = total_q + TOT_W'(util_q);
              end
            end
            FN_YIELD: begin
              if (!tok_end.hit) begin
                res_d.status = ST_UNKNOWN;
              end else if (tok_end.skip) begin
                res_d.status = ST_SKIPPED;
              end
            end
            FN_DEREGISTER: begin
              if (!tok_end.hit) begin
                res_d.status = ST_UNKNOWN;
              end else begin
                total_d = total_q - TOT_W'(tok_end.hit_util);
              end
            end
            FN_TICK: ;
            default: ;
          endcase
          // dispatch: start the shortest ready period, preempt only a longer one
          res_d.preempt_valid = 1'b0;
          res_d.preempted_id  = '0;
          if (tok_end.best_vld && !rp) begin
            start_en   = 1'b1;
            run_slot_d = bidx[TASK_SLOTS];
            run_pres_d = 1'b1;
            res_d.running_id = tok_end.best_id;
          end else if (tok_end.best_vld && tok_end.best_per < tok_end.run_per) begin
            start_en   = 1'b1;
            stop_en    = 1'b1;
            run_slot_d = bidx[TASK_SLOTS];
            run_pres_d = 1'b1;
            res_d.running_id    = tok_end.best_id;
            res_d.preempt_valid = 1'b1;
            res_d.preempted_id  = tok_end.run_id;
          end else begin
            run_pres_d       = rp;
            res_d.running_id = rp ? tok_end.run_id : '0;
          end
          res_d.running_valid = run_pres_d;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      now_q      <= '0;
      run_slot_q <= '0;
      run_pres_q <= 1'b0;
      total_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      run_slot_q <= run_slot_d;
      run_pres_q <= run_pres_d;
      total_q    <= total_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    util_q  <= util_d;
    admit_q <= admit_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");

  a_chain_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !tok_end.vld) else $error("sweep token left the chain while idle");

  a_preempt_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.preempt_valid) |-> res_o.running_valid)
    else $error("preemption reported without a running task");
`endif

endmodule

`default_nettype wire
